FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL; they compile away under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`define GHA_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`else
`define GHA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GHA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define GHA_ASSERT_ALWAYS(label, clk, rst_n, cond)
`endif
`endif

FILE: rtl/gha_pkg.sv
// Types and constants of the generational handle allocator.
package gha_pkg;

  localparam int SLOT_BITS_DEF = 8;
  localparam int GEN_BITS_DEF  = 8;

  localparam int HSLOT_W = 8;
  localparam int HGEN_W  = 8;
  localparam int LIVE_W  = 9;

  typedef enum logic [1:0] {
    MODE_CREATE  = 2'd0,
    MODE_DESTROY = 2'd1,
    MODE_CHECK   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_NOT_ALIVE = 2'd2
  } status_t;

  typedef struct packed {
    mode_t               mode;
    logic [HSLOT_W-1:0]  handle_slot;
    logic [HGEN_W-1:0]   handle_generation;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [HSLOT_W-1:0]  out_slot;
    logic [HGEN_W-1:0]   out_generation;
    logic                is_alive;
    logic [LIVE_W-1:0]   live_total;
  } out_item_t;

endpackage

FILE: rtl/generational_handle_allocator_top.sv
// Generational handle allocator: slot table, free-slot queue and counters.
//
//   channel | ports                           | item
//   --------+---------------------------------+--------------------------------
//   input   | in_valid, in_ready, in_data     | mode, handle slot, generation
//   result  | out_valid, out_ready, out_data  | status, slot, gen, alive, live
//
// Accept edge reads the slot table and the free-queue head; once the result side is free,
//   the write-back stage updates both and loads the result register, which drives out_data.
// One item per cycle unless the result stalls: table and queue have separate read and
//   write ports, and forwarding covers back-to-back items touching the same entry.
// Reset clears counters, pointers and valid flags only; entries at or above slots_used
//   are never used, and a slot's entry is written when it is first handed out.
// A stalled result holds the item in the read stage; in_ready drops only then.
`include "assert_macros.svh"

module generational_handle_allocator_top #(
  parameter int SLOT_BITS = gha_pkg::SLOT_BITS_DEF,
  parameter int GEN_BITS  = gha_pkg::GEN_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gha_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gha_pkg::out_item_t out_data
);

  localparam int NUM_SLOTS = 1 << SLOT_BITS;
  localparam int CNT_W     = SLOT_BITS + 1;
  localparam int TAB_W     = GEN_BITS + 1;           // {alive, generation}
  localparam int FF_W      = SLOT_BITS + GEN_BITS;   // {slot, generation}
  // compare widths wide enough for both the handle field and the stored value
  localparam int SCMP_W    = (CNT_W > gha_pkg::HSLOT_W) ? CNT_W : gha_pkg::HSLOT_W;
  localparam int GCMP_W    = (GEN_BITS > gha_pkg::HGEN_W) ? GEN_BITS : gha_pkg::HGEN_W;

  // Memories
  logic [TAB_W-1:0] tab_mem [NUM_SLOTS];
  logic [FF_W-1:0]  ff_mem  [NUM_SLOTS];

  // Read stage
  logic              s1_valid_r, s1_valid_nxt;
  gha_pkg::in_item_t s1_item_r;
  logic [TAB_W-1:0]  tab_rd_r;
  logic [FF_W-1:0]   ff_rd_r;
  logic              byp_tab_hit_r;
  logic [TAB_W-1:0]  byp_tab_data_r;
  logic              byp_ff_hit_r;
  logic [FF_W-1:0]   byp_ff_data_r;

  // Allocator state
  logic [CNT_W-1:0]     slots_used_r, slots_used_nxt;
  logic [SLOT_BITS-1:0] head_r, head_nxt;
  logic [SLOT_BITS-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]     fifo_cnt_r, fifo_cnt_nxt;
  logic [CNT_W-1:0]     live_r, live_nxt;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  gha_pkg::out_item_t out_data_r, out_data_nxt;

  // Handshake
  logic out_free, s2_fire, in_fire;
  logic [SLOT_BITS-1:0] in_addr;

  // Write-back stage signals
  logic [TAB_W-1:0]     tab_q;
  logic [FF_W-1:0]      ff_q;
  logic [SLOT_BITS-1:0] h_slot;
  logic [GEN_BITS-1:0]  tab_gen, gen_inc;
  logic                 slot_in_range, gen_match, handle_ok;
  logic                 tab_we, ff_we;
  logic [SLOT_BITS-1:0] tab_waddr, new_slot;
  logic [TAB_W-1:0]     tab_wdata;
  logic [FF_W-1:0]      ff_wdata;
  logic [GEN_BITS-1:0]  new_gen;
  logic                 got;

  assign out_free = !out_valid_r || out_ready;
  assign s2_fire  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;
  assign in_addr  = SLOT_BITS'(in_data.handle_slot);

  // forwarded read data: a write-back on the accept edge wins over the array
  assign tab_q   = byp_tab_hit_r ? byp_tab_data_r : tab_rd_r;
  assign ff_q    = byp_ff_hit_r  ? byp_ff_data_r  : ff_rd_r;
  assign h_slot  = SLOT_BITS'(s1_item_r.handle_slot);
  assign tab_gen = tab_q[GEN_BITS-1:0];
  assign gen_inc = tab_gen + GEN_BITS'(1);

  // slot beyond the fill count is never alive; wide generation never matches
  assign slot_in_range = SCMP_W'(s1_item_r.handle_slot) < SCMP_W'(slots_used_r);
  assign gen_match     = GCMP_W'(tab_gen) == GCMP_W'(s1_item_r.handle_generation);
  assign handle_ok     = slot_in_range && tab_q[GEN_BITS] && gen_match;

  always_comb begin
    slots_used_nxt = slots_used_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    fifo_cnt_nxt   = fifo_cnt_r;
    live_nxt       = live_r;
    tab_we         = 1'b0;
    tab_waddr      = h_slot;
    tab_wdata      = {1'b0, gen_inc};
    ff_we          = 1'b0;
    ff_wdata       = {h_slot, gen_inc};
    new_slot       = ff_q[FF_W-1:GEN_BITS];
    new_gen        = ff_q[GEN_BITS-1:0];
    got            = 1'b0;
    out_data_nxt   = out_data_r;

    if (s2_fire) begin
      out_data_nxt                = '0;
      out_data_nxt.status         = gha_pkg::ST_OK;
      case (s1_item_r.mode)
        gha_pkg::MODE_CREATE: begin
          if (fifo_cnt_r != '0) begin
            // reuse the oldest freed slot; its generation travels with it
            got          = 1'b1;
            head_nxt     = head_r + SLOT_BITS'(1);
            fifo_cnt_nxt = fifo_cnt_r - CNT_W'(1);
          end else if (!slots_used_r[SLOT_BITS]) begin
            // first use of a fresh slot: generation starts at zero
            got            = 1'b1;
            new_slot       = slots_used_r[SLOT_BITS-1:0];
            new_gen        = '0;
            slots_used_nxt = slots_used_r + CNT_W'(1);
          end
          if (got) begin
            tab_we                      = 1'b1;
            tab_waddr                   = new_slot;
            tab_wdata                   = {1'b1, new_gen};
            live_nxt                    = live_r + CNT_W'(1);
            out_data_nxt.out_slot       = gha_pkg::HSLOT_W'(new_slot);
            out_data_nxt.out_generation = gha_pkg::HGEN_W'(new_gen);
          end else begin
            out_data_nxt.status = gha_pkg::ST_EXHAUSTED;
          end
        end
        gha_pkg::MODE_DESTROY: begin
          if (handle_ok) begin
            tab_we       = 1'b1;
            ff_we        = 1'b1;
            tail_nxt     = tail_r + SLOT_BITS'(1);
            fifo_cnt_nxt = fifo_cnt_r + CNT_W'(1);
            if (live_r != '0) begin
              live_nxt = live_r - CNT_W'(1);
            end
          end else begin
            out_data_nxt.status = gha_pkg::ST_NOT_ALIVE;
          end
        end
        gha_pkg::MODE_CHECK: begin
          out_data_nxt.is_alive = handle_ok;
        end
        default: begin
        end
      endcase
      out_data_nxt.live_total = gha_pkg::LIVE_W'(live_nxt);
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s2_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Slot table: one write, one registered read
  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    if (in_fire) begin
      tab_rd_r <= tab_mem[in_addr];
    end
  end

  // Free-slot queue: written at the tail, read at the head after this edge
  always_ff @(posedge clk) begin
    if (ff_we) begin
      ff_mem[tail_r] <= ff_wdata;
    end
    if (in_fire) begin
      ff_rd_r <= ff_mem[head_nxt];
    end
  end

  // Read-stage payload and forwarding
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r      <= in_data;
      byp_tab_hit_r  <= tab_we && (tab_waddr == in_addr);
      byp_tab_data_r <= tab_wdata;
      byp_ff_hit_r   <= ff_we && (tail_r == head_nxt);
      byp_ff_data_r  <= ff_wdata;
    end
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      slots_used_r <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      fifo_cnt_r   <= '0;
      live_r       <= '0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      slots_used_r <= slots_used_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      fifo_cnt_r   <= fifo_cnt_nxt;
      live_r       <= live_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // every slot handed out is either alive or waiting in the free queue
  `GHA_ASSERT_ALWAYS(a_slot_balance, clk, rst_n, live_r + fifo_cnt_r == slots_used_r)
  `GHA_ASSERT_NEXT(a_create_live, clk, rst_n, got, live_r == $past(live_r) + CNT_W'(1))
  `GHA_ASSERT_NEXT(a_destroy_queue, clk, rst_n, ff_we, fifo_cnt_r == $past(fifo_cnt_r) + CNT_W'(1))
  `GHA_ASSERT_ALWAYS(a_used_bound, clk, rst_n, slots_used_r <= CNT_W'(NUM_SLOTS))
  `GHA_ASSERT_IMPL(a_stall_holds, clk, rst_n, s1_valid_r && !out_free, !in_ready && !tab_we)

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the generational handle allocator.
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_SLOTS = 1 << gha_pkg::SLOT_BITS_DEF;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 400_000;
  localparam int LONG_HOLD = 300;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  gha_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  gha_pkg::out_item_t out_data;

  generational_handle_allocator_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted allocator state, advanced once per accepted item
  logic [gha_pkg::HGEN_W-1:0]  slot_gen [NUM_SLOTS];
  bit                          slot_alive [NUM_SLOTS];
  int unsigned                 slots_issued;
  logic [gha_pkg::HSLOT_W-1:0] recycled_slots [$];
  int unsigned                 live_handles;

  gha_pkg::out_item_t pending_results [$];
  gha_pkg::out_item_t last_result;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit idle_enable = 1'b1;
  bit hold_req = 1'b0;

  function automatic bit handle_is_live(logic [gha_pkg::HSLOT_W-1:0] s,
                                        logic [gha_pkg::HGEN_W-1:0] g);
    if (s >= slots_issued) return 1'b0;
    return slot_alive[s] && (slot_gen[s] == g);
  endfunction

  function automatic gha_pkg::out_item_t apply_handle_op(gha_pkg::in_item_t it);
    gha_pkg::out_item_t r;
    logic [gha_pkg::HSLOT_W-1:0] s;
    r = '0;
    r.status = gha_pkg::ST_OK;
    case (it.mode)
      gha_pkg::MODE_CREATE: begin
        if (recycled_slots.size() > 0) begin
          s = recycled_slots.pop_front();
        end else if (slots_issued < NUM_SLOTS) begin
          s = slots_issued[gha_pkg::HSLOT_W-1:0];
          slots_issued++;
        end else begin
          r.status = gha_pkg::ST_EXHAUSTED;
        end
        if (r.status == gha_pkg::ST_OK) begin
          slot_alive[s] = 1'b1;
          live_handles++;
          r.out_slot = s;
          r.out_generation = slot_gen[s];
        end
      end
      gha_pkg::MODE_DESTROY: begin
        if (handle_is_live(it.handle_slot, it.handle_generation)) begin
          s = it.handle_slot;
          slot_alive[s] = 1'b0;
          slot_gen[s] = slot_gen[s] + 1'b1;   // wraps at the generation width
          recycled_slots = {recycled_slots, s};
          if (live_handles > 0) live_handles--;
        end else begin
          r.status = gha_pkg::ST_NOT_ALIVE;
        end
      end
      gha_pkg::MODE_CHECK: r.is_alive = handle_is_live(it.handle_slot, it.handle_generation);
      default: ;   // unused code: no effect
    endcase
    r.live_total = live_handles[gha_pkg::LIVE_W-1:0];
    return r;
  endfunction

  function automatic gha_pkg::in_item_t make_op(logic [1:0] m,
                                                logic [gha_pkg::HSLOT_W-1:0] s,
                                                logic [gha_pkg::HGEN_W-1:0] g);
    gha_pkg::in_item_t it;
    it.mode = gha_pkg::mode_t'(m);
    it.handle_slot = s;
    it.handle_generation = g;
    return it;
  endfunction

  // Mostly live handles, some stale ones, the rest pure noise
  function automatic gha_pkg::in_item_t pick_handle_op(int unsigned create_pct);
    gha_pkg::in_item_t it;
    int unsigned r;
    int unsigned start;
    int unsigned s;
    int k;
    it.handle_slot = gha_pkg::HSLOT_W'($urandom);
    it.handle_generation = gha_pkg::HGEN_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < create_pct) it.mode = gha_pkg::MODE_CREATE;
    else if (r < 97) it.mode = (r % 2) ? gha_pkg::MODE_DESTROY : gha_pkg::MODE_CHECK;
    else it.mode = gha_pkg::mode_t'(MODE_UNUSED);
    r = $urandom_range(0, 99);
    if (r < 70 && live_handles > 0) begin
      start = $urandom_range(0, NUM_SLOTS - 1);
      s = start;
      for (k = 0; k < NUM_SLOTS; k++) begin
        s = (start + k) % NUM_SLOTS;
        if (slot_alive[s]) break;
      end
      it.handle_slot = gha_pkg::HSLOT_W'(s);
      it.handle_generation = slot_gen[s];
    end else if (r < 85 && slots_issued > 0) begin
      s = $urandom_range(0, slots_issued - 1);
      it.handle_slot = gha_pkg::HSLOT_W'(s);
      it.handle_generation = slot_gen[s] - 1'b1;
    end
    return it;
  endfunction

  // Offer one item, hold it until accepted, then record its prediction
  task automatic send_item(gha_pkg::in_item_t it);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    last_result = apply_handle_op(it);
    pending_results = {pending_results, last_result};
  endtask

  // Result side: random stalls, or one long hold when asked
  initial begin : result_sink
    int unsigned hold_left;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (hold_left = LONG_HOLD; hold_left > 0; hold_left--) @(posedge clk);
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic field_mismatch(string name, logic [15:0] exp_v, logic [15:0] got_v);
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin : result_check
    gha_pkg::out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.status !== exp_r.status)
          field_mismatch("status", 16'(exp_r.status), 16'(out_data.status));
        if (out_data.out_slot !== exp_r.out_slot)
          field_mismatch("out_slot", 16'(exp_r.out_slot), 16'(out_data.out_slot));
        if (out_data.out_generation !== exp_r.out_generation)
          field_mismatch("out_generation", 16'(exp_r.out_generation),
                         16'(out_data.out_generation));
        if (out_data.is_alive !== exp_r.is_alive)
          field_mismatch("is_alive", 16'(exp_r.is_alive), 16'(out_data.is_alive));
        if (out_data.live_total !== exp_r.live_total)
          field_mismatch("live_total", 16'(exp_r.live_total), 16'(out_data.live_total));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL generational_handle_allocator_top");
      $finish;
    end
  end

  // Empty pool, bad handles, unused code, reuse from the free queue
  task automatic test_directed_cases();
    send_item(make_op(gha_pkg::MODE_CHECK, 8'd0, 8'd0));       // slot beyond pool
    send_item(make_op(gha_pkg::MODE_DESTROY, 8'd0, 8'd0));     // nothing handed out yet
    send_item(make_op(MODE_UNUSED, 8'hFF, 8'hFF));
    send_item(make_op(gha_pkg::MODE_CREATE, 8'hFF, 8'hFF));    // handle fields ignored
    send_item(make_op(gha_pkg::MODE_CREATE, 8'd0, 8'd0));
    send_item(make_op(gha_pkg::MODE_CHECK, 8'd0, 8'd0));
    send_item(make_op(gha_pkg::MODE_CHECK, 8'd0, 8'd1));       // generation mismatch
    send_item(make_op(gha_pkg::MODE_CHECK, 8'd0, 8'h80));
    send_item(make_op(gha_pkg::MODE_CHECK, 8'hFF, 8'd0));      // slot beyond pool
    send_item(make_op(gha_pkg::MODE_DESTROY, 8'd1, 8'd1));     // wrong generation
    send_item(make_op(gha_pkg::MODE_DESTROY, 8'd1, 8'd0));
    send_item(make_op(gha_pkg::MODE_CHECK, 8'd1, 8'd0));       // now dead
    send_item(make_op(gha_pkg::MODE_DESTROY, 8'd1, 8'd0));     // double destroy
    send_item(make_op(gha_pkg::MODE_DESTROY, 8'd1, 8'd1));     // new gen, but not alive
    send_item(make_op(gha_pkg::MODE_CREATE, 8'd0, 8'd0));      // reuses slot 1, gen 1
    send_item(make_op(gha_pkg::MODE_CREATE, 8'd0, 8'd0));
    send_item(make_op(MODE_UNUSED, 8'd0, 8'd0));
    send_item(make_op(gha_pkg::MODE_CHECK, 8'd1, 8'd1));
    send_item(make_op(gha_pkg::MODE_DESTROY, 8'd0, 8'd0));
    send_item(make_op(gha_pkg::MODE_DESTROY, 8'd2, 8'd0));
    send_item(make_op(gha_pkg::MODE_CREATE, 8'd0, 8'd0));      // oldest freed first: slot 0
  endtask

  // One slot cycled through the free queue until its generation wraps
  task automatic test_generation_wrap();
    gha_pkg::out_item_t h;
    repeat (258) begin
      send_item(make_op(gha_pkg::MODE_CREATE, 8'd0, 8'd0));
      h = last_result;
      send_item(make_op(gha_pkg::MODE_DESTROY, h.out_slot, h.out_generation));
      if (h.out_generation[4:0] == 5'd0)
        send_item(make_op(gha_pkg::MODE_CHECK, h.out_slot, h.out_generation));
    end
  endtask

  task automatic test_random_growth();
    repeat (30) send_item(pick_handle_op(45));
  endtask

  task automatic test_pool_exhaustion();
    gha_pkg::out_item_t h;
    while (!(slots_issued == NUM_SLOTS && recycled_slots.size() == 0))
      send_item(make_op(gha_pkg::MODE_CREATE, 8'd0, 8'd0));
    repeat (3) send_item(make_op(gha_pkg::MODE_CREATE, 8'd0, 8'd0));
    send_item(make_op(gha_pkg::MODE_CHECK, 8'hFF, slot_gen[NUM_SLOTS-1]));
    send_item(make_op(gha_pkg::MODE_DESTROY, 8'hFF, slot_gen[NUM_SLOTS-1]));
    send_item(make_op(gha_pkg::MODE_CREATE, 8'd0, 8'd0));      // takes slot 255 back
    h = last_result;
    send_item(make_op(gha_pkg::MODE_CREATE, 8'd0, 8'd0));      // exhausted again
    send_item(make_op(gha_pkg::MODE_CHECK, h.out_slot, h.out_generation));
  endtask

  // Receiver holds off while items keep coming, so the input must stall
  task automatic test_output_backpressure();
    hold_req = 1'b1;
    repeat (40) send_item(pick_handle_op(35));
  endtask

  task automatic test_random_full_pool();
    repeat (60) send_item(pick_handle_op(40));
    idle_enable = 1'b0;
    repeat (30) send_item(pick_handle_op(40));
  endtask

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_gen[i] = '0;
      slot_alive[i] = 1'b0;
    end
    slots_issued = 0;
    live_handles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_generation_wrap();
    test_random_growth();
    test_pool_exhaustion();
    test_output_backpressure();
    test_random_full_pool();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS generational_handle_allocator_top");
    end else begin
      $display("FAIL generational_handle_allocator_top");
    end
    $finish;
  end

endmodule
